// ===== rtl/seg3d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package seg3d_pkg;

    // Coordinate and intermediate widths
    localparam int CW      = 24;   // coordinate
    localparam int DW      = 25;   // end minus start
    localparam int MW      = 50;   // dot product magnitude
    localparam int PW      = 100;  // product of two dot products
    localparam int NW      = 102;  // signed numerator / denominator
    localparam int AW      = 101;  // magnitude of numerator / denominator
    localparam int QW      = 58;   // line parameter magnitude, 32 fraction bits
    localparam int XW      = 86;   // line point before the guard shift
    localparam int TW      = 41;   // line point with 8 guard bits
    localparam int DIV_STEPS = QW;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_DEG  = 2'd0;
    localparam logic [1:0] REG_PAR  = 2'd1;
    localparam logic [1:0] REG_MEET = 2'd2;

    // Outcome codes
    localparam logic [1:0] OUT_CROSS  = 2'd0;
    localparam logic [1:0] OUT_MEET   = 2'd1;
    localparam logic [1:0] OUT_REJECT = 2'd2;
    localparam logic [1:0] OUT_SKEW   = 2'd3;

    // Geometry and flags that ride along the pipe
    typedef struct packed {
        logic [2:0][CW-1:0] s1;
        logic [2:0][CW-1:0] s2;
        logic [2:0][DW-1:0] u;
        logic [2:0][DW-1:0] v;
        logic               rej;   // degenerate or parallel
        logic               inb;   // both parameters in [0,1]
    } t_side;

    // Divider status
    typedef struct packed {
        logic sat_a;
        logic sat_b;
        logic neg_a;
        logic neg_b;
    } t_dflag;

endpackage

`default_nettype wire

// ===== rtl/segment_intersection_3d.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake          | Beat
// ----------+--------------------+------------------------------------------
// in        | i_valid / o_ready  | i_first_*, i_second_* end points (12 x 24b)
// out       | o_valid / i_ready  | o_outcome, o_cross_x/y/z
// config    | APB psel..pready   | 64b data, registers at paddr 0, 8, 16
//
// One beat can enter every cycle unless a stall at the output has filled the
// stages back to the input. The two line parameters come from the 58-stage
// restoring divider, one quotient bit per stage. Reset is synchronous and
// clears only the stage valid bits and the registers. A stall holds only the
// stages that are full up to the blocked output; empty stages keep filling.

module segment_intersection_3d (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire         [4:0]  paddr,
    input  wire         [63:0] pwdata,
    output logic        [63:0] prdata,
    output logic               pready,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed  [23:0] i_first_start_x,
    input  wire signed  [23:0] i_first_start_y,
    input  wire signed  [23:0] i_first_start_z,
    input  wire signed  [23:0] i_first_end_x,
    input  wire signed  [23:0] i_first_end_y,
    input  wire signed  [23:0] i_first_end_z,
    input  wire signed  [23:0] i_second_start_x,
    input  wire signed  [23:0] i_second_start_y,
    input  wire signed  [23:0] i_second_start_z,
    input  wire signed  [23:0] i_second_end_x,
    input  wire signed  [23:0] i_second_end_y,
    input  wire signed  [23:0] i_second_end_z,
    output logic               o_valid,
    input  wire                i_ready,
    output logic        [1:0]  o_outcome,
    output logic signed [23:0] o_cross_x,
    output logic signed [23:0] o_cross_y,
    output logic signed [23:0] o_cross_z
);
    import seg3d_pkg::*;

    // Stage map
    localparam int ST_DIF   = 0;
    localparam int ST_MUL   = 1;
    localparam int ST_DOT   = 2;
    localparam int ST_ABS   = 3;
    localparam int ST_PP    = 4;
    localparam int ST_PSUM  = 5;
    localparam int ST_NUM   = 6;
    localparam int ST_NABS  = 7;
    localparam int ST_DPREP = 8;
    localparam int ST_DIV0  = 9;
    localparam int ST_MU    = ST_DIV0 + DIV_STEPS;
    localparam int ST_LPP   = ST_MU + 1;
    localparam int ST_LPROD = ST_MU + 2;
    localparam int ST_LSUM  = ST_MU + 3;
    localparam int ST_PT    = ST_MU + 4;
    localparam int ST_DIFF  = ST_MU + 5;
    localparam int ST_DMAG  = ST_MU + 6;
    localparam int ST_SQ    = ST_MU + 7;
    localparam int ST_OUT   = ST_MU + 8;
    localparam int NST      = ST_OUT + 1;

    localparam logic [QW-1:0] MU_MAX = {QW{1'b1}};
    localparam logic [QW-1:0] MU_ONE = QW'(64'h1_0000_0000);
    localparam logic signed [61:0] PT_HI = 62'sd1099511627775;
    localparam logic signed [33:0] C_HI  = 34'sd8388607;
    localparam logic signed [33:0] C_LO  = -34'sd8388608;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic [11:0] r_deg_thr;
    logic [47:0] r_par_thr;
    logic [15:0] r_meet;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_thr <= 12'd1;
            r_par_thr <= 48'd28147497671;
            r_meet    <= 16'd41;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:3])
                REG_DEG:  r_deg_thr <= pwdata[11:0];
                REG_PAR:  r_par_thr <= pwdata[47:0];
                REG_MEET: r_meet    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_DEG:  prdata = {52'd0, r_deg_thr};
            REG_PAR:  prdata = {16'd0, r_par_thr};
            REG_MEET: prdata = {48'd0, r_meet};
            default:  prdata = 64'd0;
        endcase
    end

    //------------------------------------------------------------------
    // Stage valids and per-stage advance (bubbles collapse)
    //------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NST-1];

    //------------------------------------------------------------------
    // Stage 0: direction vectors, degenerate test
    //------------------------------------------------------------------
    logic signed [CW-1:0] w_s1 [3];
    logic signed [CW-1:0] w_e1 [3];
    logic signed [CW-1:0] w_s2 [3];
    logic signed [CW-1:0] w_e2 [3];
    logic [DW-1:0] w_u0 [3];
    logic [DW-1:0] w_v0 [3];
    logic [DW-1:0] w_um0 [3];
    logic [DW-1:0] w_vm0 [3];
    logic          w_deg;
    t_side         w_side0;

    assign w_s1[0] = i_first_start_x;
    assign w_s1[1] = i_first_start_y;
    assign w_s1[2] = i_first_start_z;
    assign w_e1[0] = i_first_end_x;
    assign w_e1[1] = i_first_end_y;
    assign w_e1[2] = i_first_end_z;
    assign w_s2[0] = i_second_start_x;
    assign w_s2[1] = i_second_start_y;
    assign w_s2[2] = i_second_start_z;
    assign w_e2[0] = i_second_end_x;
    assign w_e2[1] = i_second_end_y;
    assign w_e2[2] = i_second_end_z;

    logic [DW-1:0] r0_w [3];

    always_comb begin
        logic deg_u;
        logic deg_v;
        deg_u = 1'b1;
        deg_v = 1'b1;
        for (int k = 0; k < 3; k++) begin
            w_u0[k]  = {w_e1[k][CW-1], w_e1[k]} - {w_s1[k][CW-1], w_s1[k]};
            w_v0[k]  = {w_e2[k][CW-1], w_e2[k]} - {w_s2[k][CW-1], w_s2[k]};
            w_um0[k] = w_u0[k][DW-1] ? (~w_u0[k] + 1'b1) : w_u0[k];
            w_vm0[k] = w_v0[k][DW-1] ? (~w_v0[k] + 1'b1) : w_v0[k];
            if (w_um0[k] >= {13'd0, r_deg_thr}) deg_u = 1'b0;
            if (w_vm0[k] >= {13'd0, r_deg_thr}) deg_v = 1'b0;
            w_side0.s1[k] = w_s1[k];
            w_side0.s2[k] = w_s2[k];
            w_side0.u[k]  = w_u0[k];
            w_side0.v[k]  = w_v0[k];
        end
        w_deg       = deg_u || deg_v;
        w_side0.rej = w_deg;
        w_side0.inb = 1'b0;
    end

    // Side band travels with every stage
    t_side r_side [NST];
    logic  w_par;
    logic  w_inb;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= w_side0;
            for (int k = 0; k < 3; k++) begin
                r0_w[k] <= {w_s1[k][CW-1], w_s1[k]} - {w_s2[k][CW-1], w_s2[k]};
            end
        end
        for (int k = 1; k < NST; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
                if (k == ST_DPREP) r_side[k].rej <= r_side[k-1].rej | w_par;
                if (k == ST_MU)    r_side[k].inb <= w_inb;
            end
        end
    end

    //------------------------------------------------------------------
    // Stage 1: component products
    //------------------------------------------------------------------
    logic signed [49:0] r1_uu [3];
    logic signed [49:0] r1_vv [3];
    logic signed [49:0] r1_vu [3];
    logic signed [49:0] r1_wv [3];
    logic signed [49:0] r1_wu [3];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            for (int k = 0; k < 3; k++) begin
                r1_uu[k] <= $signed(r_side[ST_DIF].u[k]) * $signed(r_side[ST_DIF].u[k]);
                r1_vv[k] <= $signed(r_side[ST_DIF].v[k]) * $signed(r_side[ST_DIF].v[k]);
                r1_vu[k] <= $signed(r_side[ST_DIF].v[k]) * $signed(r_side[ST_DIF].u[k]);
                r1_wv[k] <= $signed(r0_w[k]) * $signed(r_side[ST_DIF].v[k]);
                r1_wu[k] <= $signed(r0_w[k]) * $signed(r_side[ST_DIF].u[k]);
            end
        end
    end

    //------------------------------------------------------------------
    // Stage 2: dot products
    //------------------------------------------------------------------
    logic signed [51:0] r2_duu, r2_dvv, r2_dvu, r2_dwv, r2_dwu;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DOT]) begin
            r2_duu <= 52'(r1_uu[0]) + 52'(r1_uu[1]) + 52'(r1_uu[2]);
            r2_dvv <= 52'(r1_vv[0]) + 52'(r1_vv[1]) + 52'(r1_vv[2]);
            r2_dvu <= 52'(r1_vu[0]) + 52'(r1_vu[1]) + 52'(r1_vu[2]);
            r2_dwv <= 52'(r1_wv[0]) + 52'(r1_wv[1]) + 52'(r1_wv[2]);
            r2_dwu <= 52'(r1_wu[0]) + 52'(r1_wu[1]) + 52'(r1_wu[2]);
        end
    end

    //------------------------------------------------------------------
    // Stage 3: magnitudes and signs of the dot products
    //------------------------------------------------------------------
    logic signed [51:0] w3_avu, w3_awv, w3_awu;
    logic [MW-1:0] r3_muu, r3_mvv, r3_mvu, r3_mwv, r3_mwu;
    logic          r3_svu, r3_swv, r3_swu;

    always_comb begin
        w3_avu = r2_dvu[51] ? -r2_dvu : r2_dvu;
        w3_awv = r2_dwv[51] ? -r2_dwv : r2_dwv;
        w3_awu = r2_dwu[51] ? -r2_dwu : r2_dwu;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_ABS]) begin
            r3_muu <= r2_duu[MW-1:0];
            r3_mvv <= r2_dvv[MW-1:0];
            r3_mvu <= w3_avu[MW-1:0];
            r3_mwv <= w3_awv[MW-1:0];
            r3_mwu <= w3_awu[MW-1:0];
            r3_svu <= r2_dvu[51];
            r3_swv <= r2_dwv[51];
            r3_swu <= r2_dwu[51];
        end
    end

    //------------------------------------------------------------------
    // Stage 4: partial products of the six wide products
    // 0 uu*vv, 1 vu*vu, 2 wv*vu, 3 wu*vv, 4 wv*uu, 5 vu*wu
    //------------------------------------------------------------------
    logic [MW-1:0] w4_a [6];
    logic [MW-1:0] w4_b [6];
    logic [5:0]    w4_sg;
    logic [51:0]   r4_ll [6];
    logic [49:0]   r4_lh [6];
    logic [49:0]   r4_hl [6];
    logic [47:0]   r4_hh [6];
    logic [5:0]    r4_sg;

    always_comb begin
        w4_a[0] = r3_muu; w4_b[0] = r3_mvv; w4_sg[0] = 1'b0;
        w4_a[1] = r3_mvu; w4_b[1] = r3_mvu; w4_sg[1] = 1'b0;
        w4_a[2] = r3_mwv; w4_b[2] = r3_mvu; w4_sg[2] = r3_swv ^ r3_svu;
        w4_a[3] = r3_mwu; w4_b[3] = r3_mvv; w4_sg[3] = r3_swu;
        w4_a[4] = r3_mwv; w4_b[4] = r3_muu; w4_sg[4] = r3_swv;
        w4_a[5] = r3_mvu; w4_b[5] = r3_mwu; w4_sg[5] = r3_svu ^ r3_swu;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PP]) begin
            for (int i = 0; i < 6; i++) begin
                r4_ll[i] <= w4_a[i][25:0]  * w4_b[i][25:0];
                r4_lh[i] <= w4_a[i][25:0]  * w4_b[i][49:26];
                r4_hl[i] <= w4_a[i][49:26] * w4_b[i][25:0];
                r4_hh[i] <= w4_a[i][49:26] * w4_b[i][49:26];
            end
            r4_sg <= w4_sg;
        end
    end

    //------------------------------------------------------------------
    // Stage 5: assemble the wide products
    //------------------------------------------------------------------
    logic [PW-1:0] r5_p [6];
    logic [5:0]    r5_sg;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PSUM]) begin
            for (int i = 0; i < 6; i++) begin
                r5_p[i] <= (PW'(r4_hh[i]) << 52) + (PW'(r4_lh[i]) << 26)
                         + (PW'(r4_hl[i]) << 26) + PW'(r4_ll[i]);
            end
            r5_sg <= r4_sg;
        end
    end

    //------------------------------------------------------------------
    // Stage 6: denominator and numerators
    //------------------------------------------------------------------
    logic signed [NW-1:0] w6_sv [6];
    logic signed [NW-1:0] r6_den, r6_na, r6_nb;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w6_sv[i] = r5_sg[i] ? -$signed({2'b00, r5_p[i]}) : $signed({2'b00, r5_p[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_NUM]) begin
            r6_den <= w6_sv[0] - w6_sv[1];
            r6_na  <= w6_sv[2] - w6_sv[3];
            r6_nb  <= w6_sv[4] - w6_sv[5];
        end
    end

    //------------------------------------------------------------------
    // Stage 7: magnitudes and quotient signs
    //------------------------------------------------------------------
    logic signed [NW-1:0] w7_ad, w7_aa, w7_ab;
    logic [AW-1:0] r7_dm, r7_am, r7_bm;
    logic          r7_nega, r7_negb;

    always_comb begin
        w7_ad = r6_den[NW-1] ? -r6_den : r6_den;
        w7_aa = r6_na[NW-1]  ? -r6_na  : r6_na;
        w7_ab = r6_nb[NW-1]  ? -r6_nb  : r6_nb;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_NABS]) begin
            r7_dm   <= w7_ad[AW-1:0];
            r7_am   <= w7_aa[AW-1:0];
            r7_bm   <= w7_ab[AW-1:0];
            r7_nega <= r6_na[NW-1] ^ r6_den[NW-1];
            r7_negb <= r6_nb[NW-1] ^ r6_den[NW-1];
        end
    end

    //------------------------------------------------------------------
    // Stage 8: parallel test, saturation test, divider seed
    //------------------------------------------------------------------
    logic [AW-1:0] r8_dm, r8_ra, r8_rb;
    logic [QW-1:0] r8_ba, r8_bb;
    t_dflag        r8_fl;

    assign w_par = (r7_dm == '0) || (r7_dm < {53'd0, r_par_thr});

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DPREP]) begin
            r8_dm       <= r7_dm;
            r8_ra       <= AW'(r7_am >> 26);
            r8_rb       <= AW'(r7_bm >> 26);
            r8_ba       <= {r7_am[25:0], 32'd0};
            r8_bb       <= {r7_bm[25:0], 32'd0};
            r8_fl.sat_a <= {26'd0, r7_am} >= {r7_dm, 26'd0};
            r8_fl.sat_b <= {26'd0, r7_bm} >= {r7_dm, 26'd0};
            r8_fl.neg_a <= r7_nega;
            r8_fl.neg_b <= r7_negb;
        end
    end

    //------------------------------------------------------------------
    // Divider: one quotient bit per stage, both parameters side by side
    //------------------------------------------------------------------
    logic [AW-1:0] r_dv_d  [DIV_STEPS];
    logic [AW-1:0] r_dv_ra [DIV_STEPS];
    logic [AW-1:0] r_dv_rb [DIV_STEPS];
    logic [QW-1:0] r_dv_ba [DIV_STEPS];
    logic [QW-1:0] r_dv_bb [DIV_STEPS];
    logic [QW-1:0] r_dv_qa [DIV_STEPS];
    logic [QW-1:0] r_dv_qb [DIV_STEPS];
    t_dflag        r_dv_fl [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [AW-1:0] w_d, w_ra, w_rb;
        logic [QW-1:0] w_ba, w_bb, w_qa, w_qb;
        t_dflag        w_fl;
        logic [AW:0]   w_ta, w_tb;
        logic          w_ga, w_gb;

        if (j == 0) begin : g_seed
            assign w_d  = r8_dm;
            assign w_ra = r8_ra;
            assign w_rb = r8_rb;
            assign w_ba = r8_ba;
            assign w_bb = r8_bb;
            assign w_qa = '0;
            assign w_qb = '0;
            assign w_fl = r8_fl;
        end else begin : g_chain
            assign w_d  = r_dv_d[j-1];
            assign w_ra = r_dv_ra[j-1];
            assign w_rb = r_dv_rb[j-1];
            assign w_ba = r_dv_ba[j-1];
            assign w_bb = r_dv_bb[j-1];
            assign w_qa = r_dv_qa[j-1];
            assign w_qb = r_dv_qb[j-1];
            assign w_fl = r_dv_fl[j-1];
        end

        assign w_ta = {w_ra, w_ba[QW-1]};
        assign w_tb = {w_rb, w_bb[QW-1]};
        assign w_ga = w_ta >= {1'b0, w_d};
        assign w_gb = w_tb >= {1'b0, w_d};

        always_ff @(posedge i_clk) begin
            if (w_en[ST_DIV0+j]) begin
                r_dv_d[j]  <= w_d;
                r_dv_ra[j] <= w_ga ? AW'(w_ta - {1'b0, w_d}) : w_ta[AW-1:0];
                r_dv_rb[j] <= w_gb ? AW'(w_tb - {1'b0, w_d}) : w_tb[AW-1:0];
                r_dv_ba[j] <= {w_ba[QW-2:0], 1'b0};
                r_dv_bb[j] <= {w_bb[QW-2:0], 1'b0};
                r_dv_qa[j] <= {w_qa[QW-2:0], w_ga};
                r_dv_qb[j] <= {w_qb[QW-2:0], w_gb};
                r_dv_fl[j] <= w_fl;
            end
        end
    end

    //------------------------------------------------------------------
    // Stage MU: saturate parameters, bounds check
    //------------------------------------------------------------------
    logic [QW-1:0] w_mua, w_mub;
    logic [QW-1:0] r_mu_ma, r_mu_mb;
    logic          r_mu_na, r_mu_nb;

    always_comb begin
        logic ia;
        logic ib;
        w_mua = r_dv_fl[DIV_STEPS-1].sat_a ? MU_MAX : r_dv_qa[DIV_STEPS-1];
        w_mub = r_dv_fl[DIV_STEPS-1].sat_b ? MU_MAX : r_dv_qb[DIV_STEPS-1];
        ia = (w_mua == '0) || (!r_dv_fl[DIV_STEPS-1].neg_a && w_mua <= MU_ONE);
        ib = (w_mub == '0) || (!r_dv_fl[DIV_STEPS-1].neg_b && w_mub <= MU_ONE);
        w_inb = ia && ib;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MU]) begin
            r_mu_ma <= w_mua;
            r_mu_mb <= w_mub;
            r_mu_na <= r_dv_fl[DIV_STEPS-1].neg_a;
            r_mu_nb <= r_dv_fl[DIV_STEPS-1].neg_b;
        end
    end

    //------------------------------------------------------------------
    // Stage LPP: partial products of mu * direction
    //------------------------------------------------------------------
    logic [DW-1:0] w_lu [3];
    logic [DW-1:0] w_lv [3];
    logic [53:0]   r_lp_alo [3];
    logic [53:0]   r_lp_ahi [3];
    logic [53:0]   r_lp_blo [3];
    logic [53:0]   r_lp_bhi [3];
    logic [2:0]    r_lp_sa, r_lp_sb;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_lu[k] = r_side[ST_MU].u[k][DW-1] ? (~r_side[ST_MU].u[k] + 1'b1)
                                               : r_side[ST_MU].u[k];
            w_lv[k] = r_side[ST_MU].v[k][DW-1] ? (~r_side[ST_MU].v[k] + 1'b1)
                                               : r_side[ST_MU].v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_LPP]) begin
            for (int k = 0; k < 3; k++) begin
                r_lp_alo[k] <= r_mu_ma[28:0]  * w_lu[k];
                r_lp_ahi[k] <= r_mu_ma[57:29] * w_lu[k];
                r_lp_blo[k] <= r_mu_mb[28:0]  * w_lv[k];
                r_lp_bhi[k] <= r_mu_mb[57:29] * w_lv[k];
                r_lp_sa[k]  <= r_mu_na ^ r_side[ST_MU].u[k][DW-1];
                r_lp_sb[k]  <= r_mu_nb ^ r_side[ST_MU].v[k][DW-1];
            end
        end
    end

    //------------------------------------------------------------------
    // Stage LPROD: assemble mu * direction magnitudes
    //------------------------------------------------------------------
    logic [82:0] r_lq_a [3];
    logic [82:0] r_lq_b [3];
    logic [2:0]  r_lq_sa, r_lq_sb;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_LPROD]) begin
            for (int k = 0; k < 3; k++) begin
                r_lq_a[k] <= (83'(r_lp_ahi[k]) << 29) + 83'(r_lp_alo[k]);
                r_lq_b[k] <= (83'(r_lp_bhi[k]) << 29) + 83'(r_lp_blo[k]);
            end
            r_lq_sa <= r_lp_sa;
            r_lq_sb <= r_lp_sb;
        end
    end

    //------------------------------------------------------------------
    // Stage LSUM: base + mu*dir plus rounding half
    //------------------------------------------------------------------
    logic signed [XW-1:0] w_xa [3];
    logic signed [XW-1:0] w_xb [3];
    logic signed [XW-1:0] r_lx_a [3];
    logic signed [XW-1:0] r_lx_b [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_xa[k] = r_lq_sa[k] ? -$signed({3'b000, r_lq_a[k]}) : $signed({3'b000, r_lq_a[k]});
            w_xb[k] = r_lq_sb[k] ? -$signed({3'b000, r_lq_b[k]}) : $signed({3'b000, r_lq_b[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_LSUM]) begin
            for (int k = 0; k < 3; k++) begin
                r_lx_a[k] <= $signed({{30{r_side[ST_LPROD].s1[k][CW-1]}},
                                      r_side[ST_LPROD].s1[k], 32'd0})
                           + w_xa[k] + XW'(24'h80_0000);
                r_lx_b[k] <= $signed({{30{r_side[ST_LPROD].s2[k][CW-1]}},
                                      r_side[ST_LPROD].s2[k], 32'd0})
                           + w_xb[k] + XW'(24'h80_0000);
            end
        end
    end

    //------------------------------------------------------------------
    // Stage PT: drop to 8 guard bits, saturate
    //------------------------------------------------------------------
    logic signed [TW-1:0] w_pa [3];
    logic signed [TW-1:0] w_pb [3];
    logic signed [TW-1:0] r_pt_a [3];
    logic signed [TW-1:0] r_pt_b [3];

    always_comb begin
        logic signed [61:0] ya;
        logic signed [61:0] yb;
        for (int k = 0; k < 3; k++) begin
            ya = r_lx_a[k][XW-1:24];
            yb = r_lx_b[k][XW-1:24];
            if (ya > PT_HI)       w_pa[k] = PT_HI[TW-1:0];
            else if (ya < -PT_HI) w_pa[k] = -PT_HI[TW-1:0];
            else                  w_pa[k] = ya[TW-1:0];
            if (yb > PT_HI)       w_pb[k] = PT_HI[TW-1:0];
            else if (yb < -PT_HI) w_pb[k] = -PT_HI[TW-1:0];
            else                  w_pb[k] = yb[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PT]) begin
            r_pt_a <= w_pa;
            r_pt_b <= w_pb;
        end
    end

    //------------------------------------------------------------------
    // Stage DIFF: gap and sum of the closest points
    //------------------------------------------------------------------
    logic signed [TW:0] r_df_d [3];
    logic signed [TW:0] r_df_s [3];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DIFF]) begin
            for (int k = 0; k < 3; k++) begin
                r_df_d[k] <= (TW+1)'(r_pt_a[k]) - (TW+1)'(r_pt_b[k]);
                r_df_s[k] <= (TW+1)'(r_pt_a[k]) + (TW+1)'(r_pt_b[k]);
            end
        end
    end

    //------------------------------------------------------------------
    // Stage DMAG: gap magnitudes, per-axis tolerance test
    //------------------------------------------------------------------
    logic [23:0]        w_tol;
    logic signed [TW:0] w_dabs [3];
    logic [TW-1:0]      r_dm_m [3];
    logic [2:0]         r_dm_over;
    logic signed [TW:0] r_dm_s [3];

    assign w_tol = {r_meet, 8'd0};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dabs[k] = r_df_d[k][TW] ? -r_df_d[k] : r_df_d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DMAG]) begin
            for (int k = 0; k < 3; k++) begin
                r_dm_m[k]    <= w_dabs[k][TW-1:0];
                r_dm_over[k] <= w_dabs[k][TW-1:0] > {17'd0, w_tol};
            end
            r_dm_s <= r_df_s;
        end
    end

    //------------------------------------------------------------------
    // Stage SQ: squared gaps, squared tolerance, rounded midpoint
    //------------------------------------------------------------------
    logic [47:0]        r_sq_q [3];
    logic [47:0]        r_sq_tol2;
    logic               r_sq_over;
    logic signed [23:0] w_c [3];
    logic signed [23:0] r_sq_c [3];

    always_comb begin
        logic signed [TW+1:0] t;
        logic signed [33:0]   m;
        for (int k = 0; k < 3; k++) begin
            t = (TW+2)'(r_dm_s[k]) + (TW+2)'(12'sd256);
            m = t[TW+1:9];
            if (m > C_HI)      w_c[k] = C_HI[23:0];
            else if (m < C_LO) w_c[k] = C_LO[23:0];
            else               w_c[k] = m[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SQ]) begin
            for (int k = 0; k < 3; k++) begin
                r_sq_q[k] <= r_dm_m[k][23:0] * r_dm_m[k][23:0];
            end
            r_sq_tol2 <= w_tol * w_tol;
            r_sq_over <= |r_dm_over;
            r_sq_c    <= w_c;
        end
    end

    //------------------------------------------------------------------
    // Stage OUT: distance decision and result register
    //------------------------------------------------------------------
    logic [49:0] w_dist2;
    logic        w_skew;

    assign w_dist2 = 50'(r_sq_q[0]) + 50'(r_sq_q[1]) + 50'(r_sq_q[2]);
    assign w_skew  = r_sq_over || (w_dist2 > 50'(r_sq_tol2));

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            if (r_side[ST_SQ].rej) begin
                o_outcome <= OUT_REJECT;
                o_cross_x <= '0;
                o_cross_y <= '0;
                o_cross_z <= '0;
            end else if (w_skew) begin
                o_outcome <= OUT_SKEW;
                o_cross_x <= '0;
                o_cross_y <= '0;
                o_cross_z <= '0;
            end else begin
                o_outcome <= r_side[ST_SQ].inb ? OUT_CROSS : OUT_MEET;
                o_cross_x <= r_sq_c[0];
                o_cross_y <= r_sq_c[1];
                o_cross_z <= r_sq_c[2];
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import seg3d_pkg::*;

    localparam int          LATENCY  = 76;
    localparam logic [63:0] MU_CAP   = (64'd1 << 58) - 1;
    localparam longint      PT_CAP   = (64'sd1 <<< 40) - 1;
    localparam longint      MU_ONE   = 64'sd1 <<< 32;
    localparam logic [2:0]  REG_NONE = 3'd3;   // unmapped register slot

    // end points: s1 xyz, e1 xyz, s2 xyz, e2 xyz
    typedef logic [11:0][23:0] seg_pair_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } meet_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid, o_ready, o_valid, i_ready;
    logic [1:0]  o_outcome;
    logic signed [23:0] o_cross_x, o_cross_y, o_cross_z;
    seg_pair_t   cur_pair;

    // shadow of the block's registers
    logic [11:0] deg_limit;
    logic [47:0] par_limit;
    logic [15:0] meet_tol;

    seg_pair_t pending_pairs[$];
    meet_t     expected_meets[$];
    int        n_errors;
    int        n_sent;
    logic      fired;

    segment_intersection_3d i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_first_start_x(cur_pair[0]), .i_first_start_y(cur_pair[1]),
        .i_first_start_z(cur_pair[2]), .i_first_end_x(cur_pair[3]),
        .i_first_end_y(cur_pair[4]), .i_first_end_z(cur_pair[5]),
        .i_second_start_x(cur_pair[6]), .i_second_start_y(cur_pair[7]),
        .i_second_start_z(cur_pair[8]), .i_second_end_x(cur_pair[9]),
        .i_second_end_y(cur_pair[10]), .i_second_end_z(cur_pair[11]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_outcome(o_outcome), .o_cross_x(o_cross_x), .o_cross_y(o_cross_y),
        .o_cross_z(o_cross_z)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // ---------------- predictor ----------------

    function automatic longint mag(longint a);
        return a < 0 ? -a : a;
    endfunction

    // trunc(n * 2^32 / d), magnitude capped
    function automatic longint line_param(logic signed [127:0] n, logic signed [127:0] d);
        logic              neg;
        logic [127:0]      un, ud;
        logic [199:0]      q;
        neg = n[127] ^ d[127];
        un  = n[127] ? -n : n;
        ud  = d[127] ? -d : d;
        q   = ({72'd0, un} << 32) / {72'd0, ud};
        if (q > {136'd0, MU_CAP}) q = {136'd0, MU_CAP};
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // base + mu*dir with 8 guard bits, rounded half up, capped
    function automatic longint line_point(longint base, longint mu, longint dir);
        logic signed [127:0] b, m, dd, x;
        longint r;
        b = base; m = mu; dd = dir;
        x = (b <<< 32) + m * dd + (128'sd1 <<< 23);
        x = x >>> 24;
        if (x > PT_CAP)       r = PT_CAP;
        else if (x < -PT_CAP) r = -PT_CAP;
        else                  r = longint'(x);
        return r;
    endfunction

    function automatic meet_t predict_meet(seg_pair_t p);
        longint s1[3], s2[3], u[3], v[3], w[3], pa[3], pb[3], c[3];
        longint duu, dvv, dvu, dwv, dwu, mua, mub, tol, sum, dlt, sm, t;
        logic signed [127:0] den, numa, numb, aden;
        logic   skew, deg_u, deg_v;
        meet_t  r;
        for (int k = 0; k < 3; k++) begin
            s1[k] = longint'($signed(p[k]));
            u[k]  = longint'($signed(p[3 + k])) - s1[k];
            s2[k] = longint'($signed(p[6 + k]));
            v[k]  = longint'($signed(p[9 + k])) - s2[k];
            w[k]  = s1[k] - s2[k];
            c[k]  = 0;
        end
        r.outcome = OUT_REJECT;
        t = longint'(deg_limit);
        deg_u = mag(u[0]) < t && mag(u[1]) < t && mag(u[2]) < t;
        deg_v = mag(v[0]) < t && mag(v[1]) < t && mag(v[2]) < t;
        if (!(deg_u || deg_v)) begin
            duu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
            dvv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
            dvu = v[0]*u[0] + v[1]*u[1] + v[2]*u[2];
            dwv = w[0]*v[0] + w[1]*v[1] + w[2]*v[2];
            dwu = w[0]*u[0] + w[1]*u[1] + w[2]*u[2];
            den  = 128'(duu) * 128'(dvv) - 128'(dvu) * 128'(dvu);
            aden = den < 0 ? -den : den;
            if (den != 0 && aden >= $signed({80'd0, par_limit})) begin
                numa = 128'(dwv) * 128'(dvu) - 128'(dwu) * 128'(dvv);
                numb = 128'(dwv) * 128'(duu) - 128'(dvu) * 128'(dwu);
                mua  = line_param(numa, den);
                mub  = line_param(numb, den);
                tol  = longint'(meet_tol) <<< 8;
                skew = 1'b0;
                sum  = 0;
                for (int k = 0; k < 3; k++) begin
                    pa[k] = line_point(s1[k], mua, u[k]);
                    pb[k] = line_point(s2[k], mub, v[k]);
                    dlt   = pa[k] - pb[k];
                    if (mag(dlt) > tol) skew = 1'b1;
                    else                sum += dlt * dlt;
                end
                if (skew || sum > tol * tol) begin
                    r.outcome = OUT_SKEW;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        sm = (pa[k] + pb[k] + 256) >>> 9;
                        c[k] = sm > 8388607 ? 8388607 : (sm < -8388608 ? -8388608 : sm);
                    end
                    r.outcome = (mua >= 0 && mua <= MU_ONE && mub >= 0 && mub <= MU_ONE)
                                ? OUT_CROSS : OUT_MEET;
                end
            end
        end
        r.x = c[0][23:0];
        r.y = c[1][23:0];
        r.z = c[2][23:0];
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [23:0] sat24(longint a);
        return a > 8388607 ? 24'h7FFFFF : (a < -8388608 ? 24'h800000 : a[23:0]);
    endfunction

    function automatic longint rnd_coord(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    function automatic seg_pair_t make_pair(longint a[12]);
        seg_pair_t p;
        for (int k = 0; k < 12; k++) p[k] = sat24(a[k]);
        return p;
    endfunction

    // two segments built to meet, with the meeting point inside or off the ends
    function automatic seg_pair_t crossing_pair();
        longint a[12];
        longint pt[3];
        int span, tn, rs;
        span = 1 << $urandom_range(6, 19);
        tn   = int'($urandom_range(32)) - 8;
        rs   = $urandom_range(8, 40);
        for (int k = 0; k < 3; k++) begin
            a[k]     = rnd_coord(span);
            a[3 + k] = rnd_coord(span);
            pt[k]    = a[k] + (a[3 + k] - a[k]) * tn / 16;
            a[6 + k] = rnd_coord(span);
            a[9 + k] = a[6 + k] + (pt[k] - a[6 + k]) * rs / 16;
        end
        return make_pair(a);
    endfunction

    function automatic seg_pair_t random_pair();
        longint a[12];
        int kind, k2;
        kind = $urandom_range(99);
        if (kind < 60) return crossing_pair();
        for (int k = 0; k < 12; k++) a[k] = rnd_coord(8388608);
        if (kind < 70) begin
            // one segment collapsed to a few units
            k2 = $urandom_range(1) ? 3 : 9;
            for (int k = 0; k < 3; k++)
                a[k2 + k] = a[k2 - 3 + k] + int'($urandom_range(8)) - 4;
        end else if (kind < 80) begin
            // second direction a multiple of the first, plus a nudge
            k2 = int'($urandom_range(6)) - 3;
            for (int k = 0; k < 12; k++) a[k] = rnd_coord(1 << 20);
            for (int k = 0; k < 3; k++)
                a[9 + k] = a[6 + k] + (a[3 + k] - a[k]) * (k2 == 0 ? 1 : k2)
                           + int'($urandom_range(2)) - 1;
        end
        return make_pair(a);
    endfunction

    task automatic add_pair(longint a[12]);
        pending_pairs.push_back(make_pair(a));
    endtask

    // ---------------- driver ----------------

    always @(negedge i_clk) begin
        logic calm, idle;
        calm = n_sent >= 300 && n_sent < 420;
        idle = !calm && $urandom_range(99) < 29;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || fired) begin
            if (pending_pairs.size() > 0 && !idle) begin
                cur_pair <= pending_pairs.pop_front();
                i_valid  <= 1'b1;
                n_sent   <= n_sent + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= calm || $urandom_range(99) >= 29;
    end

    // ---------------- monitor ----------------

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        meet_t want;
        fired <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) expected_meets.push_back(predict_meet(cur_pair));
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_meets.size() == 0) begin
                $display("unexpected result beat at %0t", $realtime);
                n_errors++;
            end else begin
                want = expected_meets.pop_front();
                if (o_outcome != want.outcome)
                    report_mismatch("outcome", {22'd0, o_outcome}, {22'd0, want.outcome});
                if (o_cross_x != want.x) report_mismatch("cross_x", o_cross_x, want.x);
                if (o_cross_y != want.y) report_mismatch("cross_y", o_cross_y, want.y);
                if (o_cross_z != want.z) report_mismatch("cross_z", o_cross_z, want.z);
            end
        end
    end

    // ---------------- sequence ----------------

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == {1'b0, REG_DEG})  deg_limit = val[11:0];
        if (idx == {1'b0, REG_PAR})  par_limit = val[47:0];
        if (idx == {1'b0, REG_MEET}) meet_tol  = val[15:0];
    endtask

    task automatic set_regs(logic [11:0] dg, logic [47:0] pr, logic [15:0] mt);
        reg_write({1'b0, REG_DEG}, {52'd0, dg});
        reg_write({1'b0, REG_PAR}, {16'd0, pr});
        reg_write({1'b0, REG_MEET}, {48'd0, mt});
    endtask

    // hold off until every sent pair has its result back
    task automatic drain();
        while (pending_pairs.size() > 0 || i_valid || expected_meets.size() > 0)
            @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic random_batch(int n);
        for (int k = 0; k < n; k++) pending_pairs.push_back(random_pair());
    endtask

    initial begin
        longint hi, lo;
        hi = 8388607; lo = -8388608;
        n_errors = 0; n_sent = 0; fired = 1'b0;
        i_valid = 1'b0; i_ready = 1'b0; cur_pair = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        deg_limit = 12'd1; par_limit = 48'd28147497671; meet_tol = 16'd41;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset register values
        add_pair('{0, 0, 0, 4096, 0, 0, 2048, -2048, 0, 2048, 2048, 0});      // cross mid
        add_pair('{0, 0, 0, 4096, 0, 0, 4096, 0, 0, 4096, 4096, 0});          // cross at ends
        add_pair('{0, 0, 0, 4096, 0, 0, 8192, 100, 0, 8192, 4096, 0});        // meet outside
        add_pair('{0, 0, 0, 4096, 0, 0, 2048, -2048, 4096, 2048, 2048, 4096});// skew
        add_pair('{0, 0, 0, 4096, 0, 0, 5, 5, 5, 5, 5, 5});                   // second point
        add_pair('{7, 7, 7, 7, 7, 7, 0, 0, 0, 0, 4096, 0});                   // first point
        add_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});                      // both points
        add_pair('{0, 0, 0, 4096, 0, 0, 0, 100, 0, 8192, 100, 0});            // parallel
        add_pair('{0, 0, 0, 4096, 4096, 0, 0, 0, 0, 4096, 4096, 0});          // same line
        add_pair('{0, 0, 0, 1048576, 0, 0, 0, 10, 0, 1048576, 11, 1});        // far meeting
        add_pair('{lo, lo, lo, hi, hi, hi, hi, lo, lo, lo, hi, hi});
        add_pair('{hi, hi, hi, lo, lo, lo, lo, hi, lo, hi, lo, hi});
        add_pair('{lo, 0, hi, hi, 0, lo, 0, lo, 0, 0, hi, 0});
        add_pair('{hi, hi, hi, hi, hi, lo, lo, lo, lo, lo, lo, hi});
        add_pair('{-4096, -4096, 0, 4096, 4096, 0, -4096, 4096, 0, 4096, -4096, 0});
        add_pair('{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0});                      // at threshold
        add_pair('{0, 0, 0, 1, 1, 1, 1, 0, 0, 0, 1, 1});
        random_batch(150);
        drain();

        // lowest settings: nothing degenerate, only exact parallels, zero slack
        set_regs(12'd0, 48'd0, 16'd0);
        add_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 4096, 0, 0});
        add_pair('{0, 0, 0, 4096, 0, 0, 0, 1, 0, 8192, 1, 0});
        add_pair('{0, 0, 0, 4096, 0, 0, 2048, -2048, 0, 2048, 2048, 0});
        random_batch(130);
        drain();

        // highest settings
        reg_write(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        set_regs(12'hFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        add_pair('{0, 0, 0, 4095, 4094, 0, 0, 0, 0, 4096, 0, 0});
        add_pair('{0, 0, 0, 40960, 0, 0, 0, 40960, 0, 0, 0, 40960});
        random_batch(130);
        drain();

        // middle settings
        set_regs(12'($urandom_range(1, 64)), 48'($urandom_range(1, 1 << 30)),
                 16'($urandom_range(2, 400)));
        random_batch(120);
        drain();

        // back to the reset values
        set_regs(12'd1, 48'd28147497671, 16'd41);
        random_batch(120);
        drain();

        if (n_errors == 0) begin
            $display("** segment_intersection_3d: PASSED **");
        end else begin
            $display("** segment_intersection_3d: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("** segment_intersection_3d: FAILED **");
        $finish;
    end

endmodule

// ===== segment_intersection_3d.f =====
rtl/seg3d_pkg.sv
rtl/segment_intersection_3d.sv
tb/sv/tb.sv
